// ----- hdl/rwbc_pkg.sv -----
// Package for the register write burst coalescer.
// Holds the word types, widths and queue sizing shared by all modules.
// No dependencies.
package rwbc_pkg;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int LEN_W     = 3;
    localparam int SLOTS     = 7;
    localparam int MAX_BURST = 7;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef logic [SLOTS-1:0][DATA_W-1:0] t_slots;

    typedef struct packed {
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              list_end;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] burst_addr;
        logic [LEN_W-1:0]  burst_len;
        logic [DATA_W-1:0] byte0;
        logic [DATA_W-1:0] byte1;
        logic [DATA_W-1:0] byte2;
        logic [DATA_W-1:0] byte3;
        logic [DATA_W-1:0] byte4;
        logic [DATA_W-1:0] byte5;
        logic [DATA_W-1:0] byte6;
        logic              final_burst;
    } t_out_word;

    typedef struct packed {
        logic      vld0;
        logic      vld1;
        t_out_word w0;
        t_out_word w1;
    } t_push;

endpackage

// ----- hdl/register_write_burst_coalescer.sv -----
// Register write burst coalescer. Takes one byte-write word per cycle and merges writes to
// consecutive addresses into bursts of up to MAX_BURST bytes; a word with list_end set flushes
// the open burst, so one word can produce two bursts. With the output free, a burst that a word
// closes is written into the queue and then into the output register, the second of a pair after it.
// Input ready drops only while the four-entry burst queue holds more than two bursts, which
// happens when the consumer stalls or when words keep producing two bursts each; otherwise the
// block sustains one word per cycle.
module register_write_burst_coalescer #(
    parameter int MAX_BURST = rwbc_pkg::MAX_BURST
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rwbc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rwbc_pkg::t_out_word o_out_word
);
    import rwbc_pkg::*;

    t_push     push;
    logic      room, nonempty, pop;
    t_out_word head;

    rwbc_front #(
        .MAX_BURST(MAX_BURST)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_room     (room),
        .o_push     (push)
    );

    rwbc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_pop      (pop),
        .o_room     (room),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    rwbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (nonempty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.vld1 |-> push.vld0)
        else $error("second burst pushed without a first");

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.vld0 |-> (i_in_valid && o_in_ready))
        else $error("burst pushed without an accepted word");

    a_flush_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_word.list_end)
        |-> ((push.vld1 && push.w1.final_burst) || (!push.vld1 && push.w0.final_burst)))
        else $error("list end did not flush a final burst");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.burst_len != '0))
        else $error("empty burst at the output");

endmodule

// ----- hdl/rwbc_front.sv -----
// Front end of the coalescer: accepts write words and keeps the open burst.
// Pushes zero, one or two finished bursts per word into the queue.
// Depends on rwbc_pkg.
module rwbc_front #(
    parameter int MAX_BURST = rwbc_pkg::MAX_BURST
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rwbc_pkg::t_in_word i_in_word,
    input  logic               i_room,
    output rwbc_pkg::t_push    o_push
);
    import rwbc_pkg::*;

    localparam int AW1 = ADDR_W + 1;
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_BURST);

    logic [ADDR_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]  r_count, n_count;
    t_slots            r_bytes, n_bytes;
    logic [AW1-1:0]    next_addr;
    logic              accept, join_open, emit_old;
    t_out_word         old_burst, new_burst;

    function automatic t_out_word mk_burst(input logic [ADDR_W-1:0] start,
                                           input logic [LEN_W-1:0] cnt,
                                           input t_slots bytes,
                                           input logic fin);
        t_out_word w;
        t_slots    m;
        for (int i = 0; i < SLOTS; i++) begin
            m[i] = (LEN_W'(i) < cnt) ? bytes[i] : '0;
        end
        w.burst_addr  = start;
        w.burst_len   = cnt;
        w.byte0       = m[0];
        w.byte1       = m[1];
        w.byte2       = m[2];
        w.byte3       = m[3];
        w.byte4       = m[4];
        w.byte5       = m[5];
        w.byte6       = m[6];
        w.final_burst = fin;
        return w;
    endfunction

    assign o_in_ready = i_room;
    assign accept     = i_in_valid && i_room;
    assign next_addr  = {1'b0, r_start} + AW1'(r_count);
    assign join_open  = (r_count != '0) && ({1'b0, i_in_word.wr_addr} == next_addr)
                        && (r_count < MaxLen);
    assign emit_old   = (r_count != '0) && !join_open;

    always_comb begin
        n_start = r_start;
        n_count = r_count;
        n_bytes = r_bytes;
        if (join_open) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (LEN_W'(i) == r_count) begin
                    n_bytes[i] = i_in_word.wr_data;
                end
            end
            n_count = r_count + LEN_W'(1);
        end else begin
            n_start    = i_in_word.wr_addr;
            n_bytes    = '0;
            n_bytes[0] = i_in_word.wr_data;
            n_count    = LEN_W'(1);
        end
    end

    assign old_burst = mk_burst(r_start, r_count, r_bytes, 1'b0);
    assign new_burst = mk_burst(n_start, n_count, n_bytes, 1'b1);

    always_comb begin
        o_push.vld0 = accept && (emit_old || i_in_word.list_end);
        o_push.vld1 = accept && emit_old && i_in_word.list_end;
        o_push.w0   = emit_old ? old_burst : new_burst;
        o_push.w1   = new_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_start <= '0;
        end else if (accept) begin
            r_start <= n_start;
            r_count <= i_in_word.list_end ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes <= n_bytes;
        end
    end

endmodule

// ----- hdl/rwbc_queue.sv -----
// Short burst queue between the front end and the output stage.
// Takes up to two bursts per cycle and releases at most one. Depends on rwbc_pkg.
module rwbc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rwbc_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_room,
    output logic                o_nonempty,
    output rwbc_pkg::t_out_word o_head
);
    import rwbc_pkg::*;

    t_out_word         r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_pop;

    assign o_nonempty = (r_cnt != '0);
    assign o_room     = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign do_pop     = i_pop && o_nonempty;
    assign o_head     = r_mem[r_rd];
    assign n_cnt      = r_cnt + QCNT_W'(i_push.vld0) + QCNT_W'(i_push.vld1)
                        - QCNT_W'(do_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPTR_W'(i_push.vld0) + QPTR_W'(i_push.vld1);
            r_rd  <= r_rd + QPTR_W'(do_pop);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wr] <= i_push.w0;
        end
        if (i_push.vld1) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.w1;
        end
    end

endmodule

// ----- hdl/rwbc_back.sv -----
// Output stage of the coalescer: registers one burst word for the consumer.
// Pulls from the queue whenever the register is empty or being drained.
// Depends on rwbc_pkg.
module rwbc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_nonempty,
    input  rwbc_pkg::t_out_word i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rwbc_pkg::t_out_word o_out_word
);
    import rwbc_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_pop       = i_nonempty && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head;
        end
    end

endmodule
